// File: hdl/opbrc_pkg.sv
`default_nettype none
package opbrc_pkg;

	localparam int NUM_W       = 17;
	localparam int WORD_W      = 64;
	localparam int BIT_W       = $clog2(WORD_W);
	localparam int IDX_W       = NUM_W - 1;
	localparam int WORD_IDX_W  = IDX_W - BIT_W;
	localparam int BITMAP_WORDS = 1 << WORD_IDX_W;
	localparam int POP_W       = BIT_W + 1;

	localparam int IN_FIELDS_W = WORD_IDX_W + WORD_W + 2 * NUM_W;
	localparam int IN_TDATA_W  = ((IN_FIELDS_W + 7) / 8) * 8;
	localparam int OUT_TDATA_W = ((NUM_W + 7) / 8) * 8;

	localparam int OFS_WORD_INDEX  = 0;
	localparam int OFS_WORD_DATA   = OFS_WORD_INDEX + WORD_IDX_W;
	localparam int OFS_RANGE_START = OFS_WORD_DATA + WORD_W;
	localparam int OFS_RANGE_END   = OFS_RANGE_START + NUM_W;

	localparam logic MODE_LOAD  = 1'b0;
	localparam logic MODE_QUERY = 1'b1;

	localparam logic [NUM_W-1:0] MAX_NUMBER_RESET = '1;
	localparam logic [NUM_W-1:0] EVEN_PRIME       = NUM_W'(2);

endpackage
`default_nettype wire

// File: hdl/opbrc_ram.sv
`default_nettype none
module opbrc_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

// File: hdl/odd_prime_bitmap_range_count.sv
`default_nettype none
// Prime counter over an odd-only primality bitmap of 1024 words of 64 bits, where bit b of
// word w marks 2*(64*w+b)+1 as prime. An input item with tuser 0 loads one word; an item
// with tuser 1 counts the primes in [range_start, range_end] and returns one item. A query
// walks the bitmap through the single read port of the RAM, one word a cycle, so it
// occupies the block, taking no new input item, through the states WALK, DRAIN and FINISH
// until the result is handed over; reversed, out-of-limit or empty ranges skip to FINISH.
// The bitmap is not cleared at reset: every word a query touches must be loaded first.
// max_number on the configuration port bounds both range ends; write it while idle.
module odd_prime_bitmap_range_count
	import opbrc_pkg::*;
(
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   s_axis_tvalid,
	output logic                        s_axis_tready,
	// word_index, word_data, range_start, range_end, zero pad
	input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,
	// mode
	input  wire logic                   s_axis_tuser,
	output logic                        m_axis_tvalid,
	input  wire logic                   m_axis_tready,
	// prime_count, zero pad
	output logic      [OUT_TDATA_W-1:0] m_axis_tdata,
	input  wire logic                   cfg_valid,
	output logic                        cfg_ready,
	input  wire logic [NUM_W-1:0]       cfg_data
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_WALK,
		ST_DRAIN,
		ST_FINISH
	} state_t;

	function automatic logic [POP_W-1:0] ones_in(input logic [WORD_W-1:0] v);
		logic [WORD_W-1:0] x;
		x = (v & 64'h5555555555555555) + ((v >> 1) & 64'h5555555555555555);
		x = (x & 64'h3333333333333333) + ((x >> 2) & 64'h3333333333333333);
		x = (x & 64'h0f0f0f0f0f0f0f0f) + ((x >> 4) & 64'h0f0f0f0f0f0f0f0f);
		x = (x & 64'h00ff00ff00ff00ff) + ((x >> 8) & 64'h00ff00ff00ff00ff);
		x = (x & 64'h0000ffff0000ffff) + ((x >> 16) & 64'h0000ffff0000ffff);
		x = x + (x >> 32);
		return x[POP_W-1:0];
	endfunction

	state_t                state_q;
	logic [NUM_W-1:0]      max_q;
	logic [NUM_W-1:0]      count_q;
	logic [NUM_W-1:0]      out_q;
	logic                  out_valid_q;
	logic [WORD_IDX_W-1:0] addr_q;
	logic [WORD_IDX_W-1:0] w_first_q;
	logic [WORD_IDX_W-1:0] w_last_q;
	logic [BIT_W-1:0]      lo_bits_q;
	logic [BIT_W-1:0]      top_bits_q;
	logic                  rd_valid_s1;
	logic                  rd_first_s1;
	logic                  rd_last_s1;

	logic                  in_accept;
	logic                  out_free;
	logic [WORD_IDX_W-1:0] in_word_index;
	logic [WORD_W-1:0]     in_word_data;
	logic [NUM_W-1:0]      in_start;
	logic [NUM_W-1:0]      in_end;
	logic                  range_ok;
	logic                  has_two;
	logic [IDX_W-1:0]      lo;
	logic [NUM_W-1:0]      hi;
	logic [IDX_W-1:0]      hi_m1;
	logic                  nonempty;
	logic                  ram_we;
	logic                  ram_re;
	logic [WORD_W-1:0]     ram_rdata;
	logic [WORD_W-1:0]     mask;
	logic [POP_W-1:0]      pop;

	assign in_word_index = s_axis_tdata[OFS_WORD_INDEX +: WORD_IDX_W];
	assign in_word_data  = s_axis_tdata[OFS_WORD_DATA +: WORD_W];
	assign in_start      = s_axis_tdata[OFS_RANGE_START +: NUM_W];
	assign in_end        = s_axis_tdata[OFS_RANGE_END +: NUM_W];

	assign s_axis_tready = (state_q == ST_IDLE);
	assign in_accept     = s_axis_tvalid && s_axis_tready;
	assign cfg_ready     = 1'b1;
	assign out_free      = !out_valid_q || m_axis_tready;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = OUT_TDATA_W'(out_q);

	assign range_ok = (in_start <= in_end) && (in_start <= max_q) && (in_end <= max_q);
	assign has_two  = (in_start <= EVEN_PRIME) && (in_end >= EVEN_PRIME);
	assign lo       = in_start[NUM_W-1:1];
	assign hi       = NUM_W'(({1'b0, in_end} + (NUM_W + 1)'(1)) >> 1);
	assign hi_m1    = IDX_W'(hi - NUM_W'(1));
	assign nonempty = hi > NUM_W'(lo);

	assign ram_we = in_accept && (s_axis_tuser == MODE_LOAD);
	assign ram_re = (state_q == ST_WALK);

	opbrc_ram #(
		.WIDTH(WORD_W),
		.DEPTH(BITMAP_WORDS)
	) u_bitmap (
		.clk  (clk),
		.we   (ram_we),
		.waddr(in_word_index),
		.wdata(in_word_data),
		.re   (ram_re),
		.raddr(addr_q),
		.rdata(ram_rdata)
	);

	always_comb begin
		mask = '1;
		if (rd_first_s1) begin
			mask = mask & ({WORD_W{1'b1}} << lo_bits_q);
		end
		if (rd_last_s1) begin
			mask = mask & ({WORD_W{1'b1}} >> (BIT_W'(WORD_W - 1) - top_bits_q));
		end
		pop = ones_in(ram_rdata & mask);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			max_q       <= MAX_NUMBER_RESET;
			out_valid_q <= 1'b0;
			rd_valid_s1 <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				max_q <= cfg_data;
			end
			if ((state_q == ST_FINISH) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			rd_valid_s1 <= (state_q == ST_WALK);
			if (rd_valid_s1) begin
				count_q <= count_q + NUM_W'(pop);
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_accept && (s_axis_tuser == MODE_QUERY)) begin
						count_q    <= NUM_W'(range_ok && has_two);
						w_first_q  <= lo[IDX_W-1:BIT_W];
						w_last_q   <= hi_m1[IDX_W-1:BIT_W];
						addr_q     <= lo[IDX_W-1:BIT_W];
						lo_bits_q  <= lo[BIT_W-1:0];
						top_bits_q <= hi_m1[BIT_W-1:0];
						state_q    <= (range_ok && nonempty) ? ST_WALK : ST_FINISH;
					end
				end
				ST_WALK: begin
					rd_first_s1 <= (addr_q == w_first_q);
					rd_last_s1  <= (addr_q == w_last_q);
					if (addr_q == w_last_q) begin
						state_q <= ST_DRAIN;
					end else begin
						addr_q <= addr_q + WORD_IDX_W'(1);
					end
				end
				ST_DRAIN: begin
					state_q <= ST_FINISH;
				end
				ST_FINISH: begin
					if (out_free) begin
						out_q   <= count_q;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule
`default_nettype wire
